// File: rtl/core/three_axis_rate_pid_macros.svh
// ---------------------------------------------------------------------------
// Three-axis rate PID assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef THREE_AXIS_RATE_PID_MACROS_SVH
`define THREE_AXIS_RATE_PID_MACROS_SVH

// same-cycle implication
`define TARP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("three_axis_rate_pid: implication check failed");

// next-cycle implication
`define TARP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("three_axis_rate_pid: next-cycle check failed");

`endif

// File: rtl/core/tarp_pkg.sv
// ---------------------------------------------------------------------------
// Three-axis rate PID package
// Field layout, register map, constants and fixed-point helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tarp_pkg;

	localparam int NUM_AXES     = 3;
	localparam int AXES_DEFAULT = 3;
	localparam int YAW_AXIS     = 2;

	localparam int VAL_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int GAINS_W    = 48;
	localparam int LIMIT_W    = 31;
	localparam int WIDE_W     = 34;
	localparam int PROD_W     = 43;
	localparam int MUL_W      = 51;
	localparam int PDATA_W    = 64;
	localparam int ADDR_W     = 6;
	localparam int IN_TDATA_W = 200;
	localparam int OUT_TDATA_W = 96;
	localparam int SP_LSB     = 0;
	localparam int RT_LSB     = 96;
	localparam int INTEG_BIT  = 192;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd26214400;

	localparam logic signed [WIDE_W-1:0] WRAP_HI   = 34'sd11796480;
	localparam logic signed [WIDE_W-1:0] WRAP_LO   = -34'sd11730944;
	localparam logic signed [WIDE_W-1:0] WRAP_SPAN = 34'sd23592960;
	localparam logic signed [VAL_W-1:0]  ONE_Q16   = 32'sd65536;

	typedef enum logic [2:0] {
		REG_GAINS_ROLL  = 3'd0,
		REG_GAINS_PITCH = 3'd1,
		REG_GAINS_YAW   = 3'd2,
		REG_LIMIT_ROLL  = 3'd3,
		REG_LIMIT_PITCH = 3'd4,
		REG_LIMIT_YAW   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		ACT_TICK  = 1'b0,
		ACT_CLEAR = 1'b1
	} action_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 43'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -43'sd2147483648)
			r = 32'sh80000000;
		else
			r = VAL_W'(v);
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] mul_q8(input logic [GAIN_W-1:0] gain,
			input logic signed [WIDE_W-1:0] v);
		logic signed [MUL_W-1:0] prod;
		prod = signed'({1'b0, gain}) * v;
		return sat32(PROD_W'(prod >>> 8));
	endfunction

	function automatic logic signed [VAL_W-1:0] clamp_mag(input logic signed [WIDE_W-1:0] v,
			input logic [LIMIT_W-1:0] lim);
		logic signed [WIDE_W-1:0] lim_s;
		logic signed [WIDE_W-1:0] r;
		lim_s = signed'({3'b000, lim});
		if (v > lim_s)
			r = lim_s;
		else if (v < -lim_s)
			r = -lim_s;
		else
			r = v;
		return VAL_W'(r);
	endfunction

	function automatic logic signed [VAL_W-1:0] deadband(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > -ONE_Q16 && v < ONE_Q16)
			r = '0;
		else
			r = v;
		return r;
	endfunction

	function automatic logic drive_ok(input logic [VAL_W-1:0] d);
		return (d == '0) || ((d[31:16] != 16'h0000) && ((d[31:16] != 16'hffff) ||
			(d[15:0] == 16'h0000)));
	endfunction

endpackage

// File: rtl/core/three_axis_rate_pid.sv
// ---------------------------------------------------------------------------
// Three-axis rate PID controller
// Per-axis fixed-point PID step (roll, pitch, yaw) with clamp and deadband.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: setpoints, rates, integrate
//            |     |                               | tuser: action
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: drive_roll, pitch, yaw
//  apb       | in  | psel & penable & pwrite       | gains and limits, 64-bit data
//
//  One beat per cycle while m_axis_tready is high; results come from the result register.
//  The per-axis arithmetic sits between the input stage and the result register.
//  Integral and previous error update when a beat moves into the result register.
//  A held result keeps one more input beat waiting in the input stage.
//  Reset clears state, gains to zero, limits to 400.0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_axis_rate_pid import tarp_pkg::*; #(
	parameter int AXES = AXES_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// setpoint_roll, setpoint_pitch, setpoint_yaw, rate_x, rate_y, rate_z, integrate
	input  logic [IN_TDATA_W-1:0]     s_axis_tdata,
	// action
	input  logic                      s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// drive_roll, drive_pitch, drive_yaw
	output logic [OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	logic [GAINS_W-1:0]       gains_q [NUM_AXES];
	logic [LIMIT_W-1:0]       limit_q [NUM_AXES];
	logic                     cfg_wr;
	reg_idx_t                 reg_idx;

	logic                     valid_s1;
	action_t                  action_s1;
	logic                     integ_s1;
	logic signed [VAL_W-1:0]  sp_s1 [NUM_AXES];
	logic signed [VAL_W-1:0]  rt_s1 [NUM_AXES];
	logic                     out_valid_q;
	logic                     advance;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				gains_q[k] <= '0;
				limit_q[k] <= LIMIT_RESET;
			end
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GAINS_ROLL:  gains_q[0] <= pwdata[GAINS_W-1:0];
				REG_GAINS_PITCH: gains_q[1] <= pwdata[GAINS_W-1:0];
				REG_GAINS_YAW:   gains_q[2] <= pwdata[GAINS_W-1:0];
				REG_LIMIT_ROLL:  limit_q[0] <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_PITCH: limit_q[1] <= pwdata[LIMIT_W-1:0];
				REG_LIMIT_YAW:   limit_q[2] <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_GAINS_ROLL:  prdata = PDATA_W'(gains_q[0]);
			REG_GAINS_PITCH: prdata = PDATA_W'(gains_q[1]);
			REG_GAINS_YAW:   prdata = PDATA_W'(gains_q[2]);
			REG_LIMIT_ROLL:  prdata = PDATA_W'(limit_q[0]);
			REG_LIMIT_PITCH: prdata = PDATA_W'(limit_q[1]);
			REG_LIMIT_YAW:   prdata = PDATA_W'(limit_q[2]);
			default:         prdata = '0;
		endcase
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= action_t'(s_axis_tuser);
			integ_s1  <= s_axis_tdata[INTEG_BIT];
			for (int k = 0; k < NUM_AXES; k++) begin
				sp_s1[k] <= s_axis_tdata[SP_LSB + VAL_W*k +: VAL_W];
				rt_s1[k] <= s_axis_tdata[RT_LSB + VAL_W*k +: VAL_W];
			end
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		if (a < AXES) begin : g_on
			logic signed [VAL_W:0]    raw;
			logic signed [WIDE_W-1:0] ew;
			logic signed [VAL_W-1:0]  e;
			logic signed [VAL_W-1:0]  p_term;
			logic signed [VAL_W-1:0]  i_term;
			logic signed [VAL_W-1:0]  i_new;
			logic signed [VAL_W-1:0]  d_term;
			logic signed [WIDE_W-1:0] acc;
			logic signed [WIDE_W-1:0] sum;
			logic signed [VAL_W-1:0]  drv;
			logic signed [VAL_W-1:0]  integ_q;
			logic signed [VAL_W-1:0]  prev_q;
			logic signed [VAL_W-1:0]  drive_q;

			always_comb begin
				raw = (VAL_W+1)'(sp_s1[a]) - (VAL_W+1)'(rt_s1[a]);
				ew  = WIDE_W'(raw);
				if (a == YAW_AXIS) begin
					if (ew > WRAP_HI)
						ew = ew - WRAP_SPAN;
					else if (ew < WRAP_LO)
						ew = ew + WRAP_SPAN;
				end
				e      = sat32(PROD_W'(ew));
				p_term = mul_q8(gains_q[a][15:0], WIDE_W'(e));
				i_term = integ_s1 ? mul_q8(gains_q[a][31:16], WIDE_W'(e)) : '0;
				acc    = WIDE_W'(integ_q) + WIDE_W'(i_term);
				i_new  = clamp_mag(acc, limit_q[a]);
				d_term = mul_q8(gains_q[a][47:32], WIDE_W'(e) - WIDE_W'(prev_q));
				sum    = WIDE_W'(p_term) + WIDE_W'(i_new) + WIDE_W'(d_term);
				drv    = deadband(clamp_mag(sum, limit_q[a]));
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					integ_q <= '0;
					prev_q  <= '0;
				end else if (advance) begin
					if (action_s1 == ACT_CLEAR) begin
						integ_q <= '0;
						prev_q  <= '0;
					end else begin
						integ_q <= i_new;
						prev_q  <= e;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (advance)
					drive_q <= (action_s1 == ACT_CLEAR) ? '0 : drv;
			end

			assign m_axis_tdata[VAL_W*a +: VAL_W] = drive_q;
		end else begin : g_off
			assign m_axis_tdata[VAL_W*a +: VAL_W] = '0;
		end
	end

endmodule

// File: rtl/core/tarp_checker.sv
// ---------------------------------------------------------------------------
// Three-axis rate PID port checker
// Watches the stream ports of the top level; bound in below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_axis_rate_pid_macros.svh"

module tarp_checker import tarp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic lanes_ok;

	assign lanes_ok = drive_ok(m_axis_tdata[31:0]) && drive_ok(m_axis_tdata[63:32]) &&
		drive_ok(m_axis_tdata[95:64]);

	`TARP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`TARP_ASSERT_IMP(a_out_drop, $fell(m_axis_tvalid), $past(m_axis_tready))
	`TARP_ASSERT_IMP(a_deadband, m_axis_tvalid, lanes_ok)
	`TARP_ASSERT_IMP(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind three_axis_rate_pid tarp_checker u_tarp_checker (.*);
